// ===== rtl/ghp_pkg.sv =====
`timescale 1ns / 1ps
package ghp_pkg;

  localparam int LENGTH_BITS_DEF = 16;

  localparam logic [7:0] MAGIC_FIRST    = 8'h1f;
  localparam logic [7:0] MAGIC_SECOND   = 8'h8b;
  localparam logic [7:0] METHOD_DEFLATE = 8'h08;

  // flag byte bit positions
  localparam int FLG_HCRC    = 1;
  localparam int FLG_EXTRA   = 2;
  localparam int FLG_NAME    = 3;
  localparam int FLG_COMMENT = 4;

  localparam logic [15:0] SKIP_FIXED = 16'd6;
  localparam logic [15:0] SKIP_HCRC  = 16'd2;

  typedef enum logic [3:0] {
    PH_MAGIC1  = 4'd0,
    PH_MAGIC2  = 4'd1,
    PH_METHOD  = 4'd2,
    PH_FLAGS   = 4'd3,
    PH_FIXED   = 4'd4,
    PH_XLEN_LO = 4'd5,
    PH_XLEN_HI = 4'd6,
    PH_EXTRA   = 4'd7,
    PH_NAME    = 4'd8,
    PH_COMMENT = 4'd9,
    PH_HCRC    = 4'd10,
    PH_BODY    = 4'd11,
    PH_DRAIN   = 4'd12
  } phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic        header_valid;
    logic [15:0] header_length;
  } out_item_t;

endpackage

// ===== rtl/ghp_parser.sv =====
`timescale 1ns / 1ps
module ghp_parser #(
  parameter int LENGTH_BITS = ghp_pkg::LENGTH_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  ghp_pkg::in_item_t   item,
  output logic                emit,
  output ghp_pkg::out_item_t  result
);
  import ghp_pkg::*;

  phase_t                   phase_r, phase_nxt;
  logic [LENGTH_BITS-1:0]   pos_r, pos_nxt;
  logic [15:0]              skip_r, skip_nxt;
  logic [7:0]               flags_r, flags_nxt;
  logic [7:0]               xlo_r, xlo_nxt;

  phase_t      ph_w, np;
  logic [15:0] skip_w, skip_dec;
  logic [7:0]  flags_w, xlo_w;
  logic        fail, in_hdr;
  logic [LENGTH_BITS+15:0] pos_ext;

  // first optional part at or after 'from'
  function automatic phase_t next_phase(input phase_t from, input logic [7:0] flg);
    phase_t r;
    r = PH_BODY;
    if (from <= PH_HCRC && flg[FLG_HCRC])       r = PH_HCRC;
    if (from <= PH_COMMENT && flg[FLG_COMMENT]) r = PH_COMMENT;
    if (from <= PH_NAME && flg[FLG_NAME])       r = PH_NAME;
    if (from <= PH_XLEN_LO && flg[FLG_EXTRA])   r = PH_XLEN_LO;
    return r;
  endfunction

  assign skip_dec = skip_r - 16'd1;
  assign pos_ext  = {16'd0, pos_r};

  // header byte path
  always_comb begin
    ph_w    = phase_r;
    skip_w  = skip_r;
    flags_w = flags_r;
    xlo_w   = xlo_r;
    fail    = 1'b0;
    np      = PH_BODY;
    in_hdr  = phase_r inside {[PH_MAGIC1:PH_HCRC]};
    if (&pos_r) begin
      fail = 1'b1;
    end else begin
      case (phase_r)
        PH_MAGIC1: begin
          if (item.data_byte != MAGIC_FIRST) fail = 1'b1;
          else ph_w = PH_MAGIC2;
        end
        PH_MAGIC2: begin
          if (item.data_byte != MAGIC_SECOND) fail = 1'b1;
          else ph_w = PH_METHOD;
        end
        PH_METHOD: begin
          if (item.data_byte != METHOD_DEFLATE) fail = 1'b1;
          else ph_w = PH_FLAGS;
        end
        PH_FLAGS: begin
          flags_w = item.data_byte;
          skip_w  = SKIP_FIXED;
          ph_w    = PH_FIXED;
        end
        PH_FIXED: begin
          skip_w = skip_dec;
          if (skip_dec == 16'd0) begin
            np   = next_phase(PH_XLEN_LO, flags_r);
            ph_w = np;
            if (np == PH_HCRC) skip_w = SKIP_HCRC;
          end
        end
        PH_XLEN_LO: begin
          xlo_w = item.data_byte;
          ph_w  = PH_XLEN_HI;
        end
        PH_XLEN_HI: begin
          skip_w = {item.data_byte, xlo_r};
          if ({item.data_byte, xlo_r} == 16'd0) begin
            np   = next_phase(PH_NAME, flags_r);
            ph_w = np;
            if (np == PH_HCRC) skip_w = SKIP_HCRC;
          end else begin
            ph_w = PH_EXTRA;
          end
        end
        PH_EXTRA: begin
          skip_w = skip_dec;
          if (skip_dec == 16'd0) begin
            np   = next_phase(PH_NAME, flags_r);
            ph_w = np;
            if (np == PH_HCRC) skip_w = SKIP_HCRC;
          end
        end
        PH_NAME: begin
          if (item.data_byte == 8'd0) begin
            np   = next_phase(PH_COMMENT, flags_r);
            ph_w = np;
            if (np == PH_HCRC) skip_w = SKIP_HCRC;
          end
        end
        PH_COMMENT: begin
          if (item.data_byte == 8'd0) begin
            np   = next_phase(PH_HCRC, flags_r);
            ph_w = np;
            if (np == PH_HCRC) skip_w = SKIP_HCRC;
          end
        end
        PH_HCRC: begin
          skip_w = skip_dec;
          if (skip_dec == 16'd0) ph_w = PH_BODY;
        end
        default: begin
        end
      endcase
    end
  end

  // commit and result
  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    skip_nxt  = skip_r;
    flags_nxt = flags_r;
    xlo_nxt   = xlo_r;
    emit      = 1'b0;
    result    = '0;
    if (step) begin
      if (phase_r == PH_BODY) begin
        emit                 = 1'b1;
        result.header_valid  = 1'b1;
        result.header_length = pos_ext[15:0];
      end else if (in_hdr && (fail || item.last_byte)) begin
        emit = 1'b1;
      end

      if (item.last_byte) begin
        phase_nxt = PH_MAGIC1;
        pos_nxt   = '0;
        skip_nxt  = '0;
        flags_nxt = '0;
        xlo_nxt   = '0;
      end else if (phase_r == PH_BODY || (in_hdr && fail)) begin
        phase_nxt = PH_DRAIN;
      end else if (in_hdr) begin
        phase_nxt = ph_w;
        pos_nxt   = pos_r + {{(LENGTH_BITS-1){1'b0}}, 1'b1};
        skip_nxt  = skip_w;
        flags_nxt = flags_w;
        xlo_nxt   = xlo_w;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_MAGIC1;
      pos_r   <= '0;
      skip_r  <= '0;
      flags_r <= '0;
      xlo_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      skip_r  <= skip_nxt;
      flags_r <= flags_nxt;
      xlo_r   <= xlo_nxt;
    end
  end

  a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (step && item.last_byte) |=> (phase_r == PH_MAGIC1 && pos_r == '0))
    else $error("state not cleared after last byte");

  a_pos_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(pos_r))
    else $error("position moved without a request");

  a_valid_from_body: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && result.header_valid) |-> (phase_r == PH_BODY))
    else $error("valid header reported outside body phase");

endmodule

// ===== rtl/gzip_header_parser.sv =====
`timescale 1ns / 1ps
// channel | ports                          | payload
// --------+--------------------------------+---------------------------------
// input   | in_valid, in_stall, in_data    | data_byte, last_byte
// output  | out_valid, out_stall, out_data | header_valid, header_length
//
// One request per cycle unless a held result stalls the input; the edge of
// acceptance loads the input register, and consuming that byte parses it into
// the result register, from which a result (if the byte yields one) is offered.
// The per-byte parse state updates as each byte is consumed, which sets that rate.
// Synchronous active-low reset returns the parser to the first magic byte.
// A stalled result holds the output register; in_stall rises only while the
// input register is full and the result register is held.
module gzip_header_parser #(
  parameter int LENGTH_BITS = ghp_pkg::LENGTH_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ghp_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ghp_pkg::out_item_t  out_data
);
  import ghp_pkg::*;

  logic       in_full_r, in_full_nxt;
  in_item_t   in_item_r;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_item_r;
  logic       consume, load, emit;
  out_item_t  result;

  assign consume     = in_full_r && !(out_valid_r && out_stall);
  assign in_stall    = in_full_r && !consume;
  assign load        = in_valid && !in_stall;
  assign in_full_nxt = load || (in_full_r && !consume);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (consume && emit) out_valid_nxt = 1'b1;
    else if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
  end

  ghp_parser #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (consume),
    .item   (in_item_r),
    .emit   (emit),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_full_r   <= in_full_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) in_item_r <= in_data;
    if (consume && emit) out_item_r <= result;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  a_invalid_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.header_valid || out_data.header_length == 16'd0))
    else $error("invalid result carries a length");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !(consume && emit))
    else $error("held result overwritten");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (in_full_r && out_valid_r))
    else $error("input stalled with room available");

endmodule
